>>> rtl/core/saes_pkg.sv
`default_nettype none

package saes_pkg;

    // Operation selector carried in tuser
    typedef enum logic {
        REQ_ENCRYPT = 1'b0,
        REQ_DECRYPT = 1'b1
    } req_type_t;

    // Round constants for the key schedule
    localparam logic [7:0] RCON_1 = 8'h80;
    localparam logic [7:0] RCON_2 = 8'h30;

    // Mix-columns matrix entries: forward [1 4; 4 1], inverse [9 2; 2 9]
    localparam logic [3:0] MIX_FWD_DIAG = 4'h1;
    localparam logic [3:0] MIX_FWD_OFF  = 4'h4;
    localparam logic [3:0] MIX_INV_DIAG = 4'h9;
    localparam logic [3:0] MIX_INV_OFF  = 4'h2;

    typedef struct packed {
        logic [15:0] k0;
        logic [15:0] k1;
        logic [15:0] k1_imc;
        logic [15:0] k2;
    } round_keys_t;

    function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
        logic [3:0] r;
        case (n)
            4'h0: r = 4'h9;
            4'h1: r = 4'h4;
            4'h2: r = 4'hA;
            4'h3: r = 4'hB;
            4'h4: r = 4'hD;
            4'h5: r = 4'h1;
            4'h6: r = 4'h8;
            4'h7: r = 4'h5;
            4'h8: r = 4'h6;
            4'h9: r = 4'h2;
            4'hA: r = 4'h0;
            4'hB: r = 4'h3;
            4'hC: r = 4'hC;
            4'hD: r = 4'hE;
            4'hE: r = 4'hF;
            4'hF: r = 4'h7;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] sbox_inv(input logic [3:0] n);
        logic [3:0] r;
        case (n)
            4'h0: r = 4'hA;
            4'h1: r = 4'h5;
            4'h2: r = 4'h9;
            4'h3: r = 4'hB;
            4'h4: r = 4'h1;
            4'h5: r = 4'h7;
            4'h6: r = 4'h8;
            4'h7: r = 4'hF;
            4'h8: r = 4'h6;
            4'h9: r = 4'h0;
            4'hA: r = 4'h2;
            4'hB: r = 4'h3;
            4'hC: r = 4'hC;
            4'hD: r = 4'h4;
            4'hE: r = 4'hD;
            4'hF: r = 4'hE;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sub_nibbles(input logic [15:0] s, input logic inv);
        logic [15:0] r;
        for (int i = 0; i < 4; i++) begin
            r[i*4 +: 4] = inv ? sbox_inv(s[i*4 +: 4]) : sbox_fwd(s[i*4 +: 4]);
        end
        return r;
    endfunction

    // Swap nibbles 1 and 3 (bits 11..8 and 3..0)
    function automatic logic [15:0] shift_rows(input logic [15:0] s);
        return {s[15:12], s[3:0], s[7:4], s[11:8]};
    endfunction

    // GF(16) multiply, modulus x^4 + x + 1
    function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] p;
        logic [3:0] aa;
        p  = 4'h0;
        aa = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
                p = p ^ aa;
            end
            aa = aa[3] ? ({aa[2:0], 1'b0} ^ 4'h3) : {aa[2:0], 1'b0};
        end
        return p;
    endfunction

    function automatic logic [7:0] mix_byte(input logic [7:0] col,
                                            input logic [3:0] diag,
                                            input logic [3:0] off);
        logic [3:0] t;
        logic [3:0] b;
        t = col[7:4];
        b = col[3:0];
        return {gf16_mul(diag, t) ^ gf16_mul(off, b), gf16_mul(off, t) ^ gf16_mul(diag, b)};
    endfunction

    function automatic logic [15:0] mix_columns(input logic [15:0] s,
                                                input logic [3:0] diag,
                                                input logic [3:0] off);
        return {mix_byte(s[15:8], diag, off), mix_byte(s[7:0], diag, off)};
    endfunction

    // Key-schedule g: rotate nibbles, substitute, add round constant
    function automatic logic [7:0] key_g(input logic [7:0] w, input logic [7:0] rc);
        return {sbox_fwd(w[3:0]), sbox_fwd(w[7:4])} ^ rc;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/simplified_aes_cipher_unit.sv
// Simplified AES (S-AES) on a 16-bit block with a 16-bit key. Write the key
// through cfg_we/cfg_wdata while no item is in flight; the three round keys
// are expanded from the key register into a round-key register. Each input
// item carries the block in s_tdata and the operation in s_tuser (0 encrypt,
// 1 decrypt) and produces exactly one result item in m_tdata. The block
// takes one item per cycle while the output is not stalled: an item waits in
// the input register while both cipher rounds run through one pass of
// nibble-substitution, row-shift, column-mix and XOR logic, and the result is
// captured in the output register once that slot is free, raising m_tvalid.
// While a result waits there, the input register still takes one more item;
// s_tready drops only when both registers are full and m_tready is low.
`default_nettype none

module simplified_aes_cipher_unit
    import saes_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,   // [15:0] cipher_key
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [15:0] data_in
    input  wire logic        s_tuser,     // [0] req_type
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata      // [15:0] data_out
);

    round_keys_t keys;

    // Input register stage
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_type_reg;
    logic [15:0] in_data_reg;

    // Output register stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] out_data_reg;
    logic [15:0] result;

    logic out_load;
    logic in_load;

    saes_key_sched u_key_sched (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .keys      (keys)
    );

    saes_datapath u_datapath (
        .req_type (in_type_reg),
        .data_in  (in_data_reg),
        .keys     (keys),
        .data_out (result)
    );

    // Output slot is free when empty or being drained this cycle
    assign out_load = !out_valid_reg || m_tready;
    // Input slot is free when empty or its item moves on this cycle
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_type_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // An item in the input stage with a free output slot moves to the output
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input-stage item did not reach output register");

    // Ready drops only when the input stage holds a blocked item
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("s_tready low without backpressure");

    // A stalled output with a full input stage keeps the input item in place
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |=>
            (in_valid_reg && $stable(in_data_reg) && $stable(in_type_reg)))
        else $error("input-stage item lost during stall");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_valid_reg))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

>>> rtl/core/saes_key_sched.sv
`default_nettype none

module saes_key_sched
    import saes_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output round_keys_t      keys
);

    logic [15:0] key_reg;
    round_keys_t keys_reg;
    round_keys_t keys_next;
    logic [7:0]  w2;
    logic [7:0]  w3;
    logic [7:0]  w4;
    logic [7:0]  w5;

    always_comb begin
        w2 = key_reg[15:8] ^ key_g(key_reg[7:0], RCON_1);
        w3 = w2 ^ key_reg[7:0];
        w4 = w2 ^ key_g(w3, RCON_2);
        w5 = w4 ^ w3;
        keys_next.k0     = key_reg;
        keys_next.k1     = {w2, w3};
        keys_next.k1_imc = mix_columns({w2, w3}, MIX_INV_DIAG, MIX_INV_OFF);
        keys_next.k2     = {w4, w5};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_we) begin
            key_reg <= cfg_wdata;
        end
    end

    // Round keys follow the key register through a second register
    always_ff @(posedge aclk) begin
        keys_reg <= keys_next;
    end

    assign keys = keys_reg;

endmodule

`default_nettype wire

>>> rtl/core/saes_datapath.sv
`default_nettype none

module saes_datapath
    import saes_pkg::*;
(
    input  wire logic        req_type,
    input  wire logic [15:0] data_in,
    input  wire round_keys_t keys,
    output logic      [15:0] data_out
);

    logic        dec;
    logic [15:0] key_first;
    logic [15:0] key_mid;
    logic [15:0] key_last;
    logic [15:0] s0;
    logic [15:0] s1;
    logic [15:0] s2;

    always_comb begin
        dec       = (req_type == REQ_DECRYPT);
        key_first = dec ? keys.k2     : keys.k0;
        key_mid   = dec ? keys.k1_imc : keys.k1;
        key_last  = dec ? keys.k0     : keys.k2;

        s0 = data_in ^ key_first;
        s1 = shift_rows(sub_nibbles(s0, dec));
        s1 = dec ? mix_columns(s1, MIX_INV_DIAG, MIX_INV_OFF)
                 : mix_columns(s1, MIX_FWD_DIAG, MIX_FWD_OFF);
        s1 = s1 ^ key_mid;
        s2 = shift_rows(sub_nibbles(s1, dec));
        data_out = s2 ^ key_last;
    end

endmodule

`default_nettype wire

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import saes_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 3;
    // Pad generously around key writes and at the end
    localparam int PIPE_SETTLE     = 4;
    localparam int TAIL_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 106;
    localparam int NUM_ROWS        = 20;

    // Nibble substitution tables, entry n at bits 4n+3..4n
    localparam logic [63:0] SUB_FWD = 64'h7FEC_3026_581D_BA49;
    localparam logic [63:0] SUB_INV = 64'hED4C_3206_F871_B95A;

    // One directed stimulus row. A row with typed set carries its result in the table,
    // every other row goes through the cipher predictor.
    typedef struct {
        logic        new_key;
        logic [15:0] key;
        req_type_t   op;
        logic [15:0] blk;
        logic        typed;
        logic [15:0] result;
    } dir_row_t;

    typedef struct {
        req_type_t   op;
        logic [15:0] blk;
        logic [15:0] result;
    } pending_block_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'h0000;   // [15:0] data_in
    logic        s_tuser   = 1'b0;       // [0] req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;                // [15:0] data_out

    // Predictor copy of the key register, and the blocks still owed by the unit
    logic [15:0]    key_shadow = 16'h0000;
    pending_block_t pending_blocks[$];

    // Side info that travels with the item on the input bus
    logic        row_typed  = 1'b0;
    logic [15:0] row_result = 16'h0000;

    int error_count = 0;
    int idle_cycles = 0;
    int stall_pct   = 30;
    int stall_left  = 0;

    dir_row_t dir_rows [NUM_ROWS];

    simplified_aes_cipher_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------

    function automatic logic [15:0] substitute(input logic [15:0] s, input logic [63:0] tab);
        logic [15:0] r;
        for (int i = 0; i < 4; i++) begin
            r[i*4 +: 4] = tab[{s[i*4 +: 4], 2'b00} +: 4];
        end
        return r;
    endfunction

    // Row shift: exchange nibbles 1 and 3, keep 0 and 2
    function automatic logic [15:0] rotate_row(input logic [15:0] s);
        return {s[15:12], s[3:0], s[7:4], s[11:8]};
    endfunction

    // GF(16) product, reduced by x^4 + x + 1
    function automatic logic [3:0] gf_times(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] p;
        logic [3:0] m;
        p = 4'h0;
        m = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
                p = p ^ m;
            end
            m = {m[2:0], 1'b0} ^ (m[3] ? 4'h3 : 4'h0);
        end
        return p;
    endfunction

    // Multiply each byte column by [d o; o d]
    function automatic logic [15:0] column_mix(input logic [15:0] s, input logic [3:0] d,
                                               input logic [3:0] o);
        logic [15:0] r;
        logic [3:0]  hi;
        logic [3:0]  lo;
        for (int c = 0; c < 2; c++) begin
            hi = s[c*8+4 +: 4];
            lo = s[c*8 +: 4];
            r[c*8+4 +: 4] = gf_times(d, hi) ^ gf_times(o, lo);
            r[c*8 +: 4]   = gf_times(o, hi) ^ gf_times(d, lo);
        end
        return r;
    endfunction

    // Key schedule word function: swap nibbles, substitute, add round constant
    function automatic logic [7:0] schedule_word(input logic [7:0] w, input logic [7:0] rc);
        return {SUB_FWD[{w[3:0], 2'b00} +: 4], SUB_FWD[{w[7:4], 2'b00} +: 4]} ^ rc;
    endfunction

    function automatic logic [15:0] saes_block(input logic [15:0] key, input req_type_t op,
                                               input logic [15:0] blk);
        logic [7:0]  w2;
        logic [7:0]  w3;
        logic [7:0]  w4;
        logic [7:0]  w5;
        logic [15:0] k1;
        logic [15:0] k2;
        logic [15:0] s;
        w2 = key[15:8] ^ schedule_word(key[7:0], RCON_1);
        w3 = w2 ^ key[7:0];
        w4 = w2 ^ schedule_word(w3, RCON_2);
        w5 = w4 ^ w3;
        k1 = {w2, w3};
        k2 = {w4, w5};
        if (op == REQ_ENCRYPT) begin
            s = blk ^ key;
            s = column_mix(rotate_row(substitute(s, SUB_FWD)), MIX_FWD_DIAG, MIX_FWD_OFF) ^ k1;
            s = rotate_row(substitute(s, SUB_FWD)) ^ k2;
        end else begin
            // Equivalent inverse: middle round key goes through inverse mix too
            s = blk ^ k2;
            s = column_mix(rotate_row(substitute(s, SUB_INV)), MIX_INV_DIAG, MIX_INV_OFF)
                ^ column_mix(k1, MIX_INV_DIAG, MIX_INV_OFF);
            s = rotate_row(substitute(s, SUB_INV)) ^ key;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Sample both buses at the rising edge: log each accepted item with its prediction,
    // check each accepted result against the oldest one, track key writes.
    always @(posedge aclk) begin : track
        pending_block_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                e.op     = req_type_t'(s_tuser);
                e.blk    = s_tdata;
                e.result = row_typed ? row_result : saes_block(key_shadow, e.op, s_tdata);
                pending_blocks.push_back(e);
            end
            if (m_tvalid && m_tready) begin
                if (pending_blocks.size() == 0) begin
                    report_mismatch($sformatf("result item %h with nothing pending", m_tdata));
                end else begin
                    e = pending_blocks.pop_front();
                    if (m_tdata !== e.result) begin
                        report_mismatch($sformatf("%s %h: data_out %h, predicted %h",
                                                  e.op.name(), e.blk, m_tdata, e.result));
                    end
                end
            end
            if (cfg_we) begin
                key_shadow = cfg_wdata;
            end
        end
    end

    // Watchdog: end the run if neither bus moves an item for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no item moved for %0d cycles, %0d pending",
                     $realtime, WATCHDOG_LIMIT, pending_blocks.size());
            $display("** simplified_aes_cipher_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall in runs of random length at a rate set per phase
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one item from a falling edge and hold it until accepted
    task automatic send_item(input req_type_t op, input logic [15:0] blk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= blk;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid, drain every pending result, let the pipe settle, then write the key
    task automatic load_key(input logic [15:0] key);
        s_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= key;
        @(negedge aclk);
        cfg_we <= 1'b0;
        // Let the round keys register from the new key before the next item
        repeat (2) @(negedge aclk);
    endtask

    initial begin
        int          burst_left;
        int          gap;
        int          max_gap;
        logic        have_plain;
        logic [15:0] last_plain;
        logic [15:0] phase_key;
        logic [15:0] blk;
        req_type_t   op;

        // Key 0 after reset: round keys 0000 / 1919 / 0D14, so a zero block encrypts to 071E
        dir_rows = '{
            '{1'b0, 16'h0000, REQ_ENCRYPT, 16'h0000, 1'b1, 16'h071E},
            '{1'b0, 16'h0000, REQ_DECRYPT, 16'h071E, 1'b1, 16'h0000},
            '{1'b0, 16'h0000, REQ_ENCRYPT, 16'hFFFF, 1'b0, 16'h0000},
            '{1'b0, 16'h0000, REQ_DECRYPT, 16'hFFFF, 1'b0, 16'h0000},
            '{1'b0, 16'h0000, REQ_DECRYPT, 16'h0000, 1'b0, 16'h0000},
            '{1'b0, 16'h0000, REQ_ENCRYPT, 16'h8000, 1'b0, 16'h0000},
            '{1'b0, 16'h0000, REQ_ENCRYPT, 16'h0001, 1'b0, 16'h0000},
            '{1'b0, 16'h0000, REQ_ENCRYPT, 16'hAAAA, 1'b0, 16'h0000},
            '{1'b0, 16'h0000, REQ_DECRYPT, 16'h5555, 1'b0, 16'h0000},
            '{1'b1, 16'hFFFF, REQ_ENCRYPT, 16'h0000, 1'b0, 16'h0000},
            '{1'b0, 16'hFFFF, REQ_ENCRYPT, 16'hFFFF, 1'b0, 16'h0000},
            '{1'b0, 16'hFFFF, REQ_DECRYPT, 16'h0000, 1'b0, 16'h0000},
            '{1'b0, 16'hFFFF, REQ_DECRYPT, 16'hFFFF, 1'b0, 16'h0000},
            '{1'b1, 16'h4AF5, REQ_ENCRYPT, 16'hD728, 1'b0, 16'h0000},
            '{1'b0, 16'h4AF5, REQ_DECRYPT, 16'h24EC, 1'b0, 16'h0000},
            '{1'b1, 16'h8001, REQ_ENCRYPT, 16'h1234, 1'b0, 16'h0000},
            '{1'b0, 16'h8001, REQ_DECRYPT, 16'h1234, 1'b0, 16'h0000},
            '{1'b0, 16'h8001, REQ_ENCRYPT, 16'h7FFE, 1'b0, 16'h0000},
            '{1'b1, 16'h0000, REQ_ENCRYPT, 16'h0000, 1'b1, 16'h071E},
            '{1'b0, 16'h0000, REQ_DECRYPT, 16'h071E, 1'b1, 16'h0000}
        };

        // Hold reset, then release it on a falling edge
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: back-to-back items apart from key loads, receiver stalls at its default rate
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (dir_rows[i].new_key) begin
                load_key(dir_rows[i].key);
            end
            row_typed  <= dir_rows[i].typed;
            row_result <= dir_rows[i].result;
            send_item(dir_rows[i].op, dir_rows[i].blk);
        end
        row_typed <= 1'b0;

        // Random part: one key per phase, extremes first
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       phase_key = 16'hFFFF;
                1:       phase_key = 16'h0000;
                2:       phase_key = 16'hA5A5;
                default: phase_key = 16'($urandom);
            endcase
            load_key(phase_key);

            // Run phases 3 and 6 with no idling on either side
            if (p == 3 || p == 6) begin
                stall_pct <= 0;
                max_gap = 0;
            end else begin
                stall_pct <= $urandom_range(10, 60);
                max_gap = $urandom_range(1, 6);
            end

            burst_left = 0;
            have_plain = 1'b0;
            last_plain = 16'h0000;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Mostly fresh blocks; often decrypt the ciphertext of the last plaintext
                if (have_plain && $urandom_range(3) == 0) begin
                    op  = REQ_DECRYPT;
                    blk = saes_block(phase_key, REQ_ENCRYPT, last_plain);
                    have_plain = 1'b0;
                end else begin
                    op = req_type_t'($urandom_range(1));
                    case ($urandom_range(15))
                        0:       blk = 16'h0000;
                        1:       blk = 16'hFFFF;
                        default: blk = 16'($urandom);
                    endcase
                    if (op == REQ_ENCRYPT) begin
                        last_plain = blk;
                        have_plain = 1'b1;
                    end
                end
                send_item(op, blk);

                // Advance the burst; at its end drop valid for a random gap
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap = $urandom_range(max_gap);
                    if (gap != 0) begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(negedge aclk);
                    end
                end else begin
                    burst_left--;
                end
            end
        end

        // Drain, then give any stray result time to show up
        s_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("** simplified_aes_cipher_unit: PASSED **");
        end else begin
            $display("** simplified_aes_cipher_unit: FAILED **");
        end
        $finish;
    end

endmodule
